// ===== src/multi_channel_bounded_fifo_macros.svh =====
// Assertion macros shared by the multi-channel bounded FIFO RTL.
// Each macro samples on clk and is disabled while rst is high.
`ifndef MULTI_CHANNEL_BOUNDED_FIFO_MACROS_SVH
`define MULTI_CHANNEL_BOUNDED_FIFO_MACROS_SVH

// Same-cycle implication.
`define MCBF_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication.
`define MCBF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== src/mcbf_pkg.sv =====
// Package for the multi-channel bounded FIFO: operation and status codes,
// field widths, the front-to-back command struct and width helpers. No dependencies.
package mcbf_pkg;

  localparam int NUM_CHANNELS_DEF = 8;
  localparam int DEPTH_DEF        = 16;
  localparam int CHANNEL_W        = 3;
  localparam int DATA_W           = 32;
  localparam int CAP_W            = 5;
  localparam int QUEUE_DEPTH      = 2;

  typedef enum logic [1:0] {
    KIND_OPEN  = 2'd0,
    KIND_CLOSE = 2'd1,
    KIND_SEND  = 2'd2,
    KIND_RECV  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_NO_CHANNEL  = 2'd1,
    ST_WOULD_BLOCK = 2'd2,
    ST_NO_FREE     = 2'd3
  } status_t;

  // Command handed from the front to the back
  typedef struct packed {
    status_t                status;
    logic [CHANNEL_W-1:0]   opened_index;
    logic                   rd;
    logic                   wr;
  } cmd_ctl_t;

  // Channels reachable through the channel field
  function automatic int chan_count(input int n);
    return (n < (1 << CHANNEL_W)) ? n : (1 << CHANNEL_W);
  endfunction

  function automatic int chan_w(input int n);
    return (chan_count(n) > 1) ? $clog2(chan_count(n)) : 1;
  endfunction

  function automatic int slot_w(input int d);
    return (d > 1) ? $clog2(d) : 1;
  endfunction

  function automatic int cnt_w(input int d);
    return $clog2(d + 1);
  endfunction

  function automatic int addr_w(input int n, input int d);
    return chan_w(n) + slot_w(d);
  endfunction

endpackage

// ===== src/mcbf_ram.sv =====
// Generic single-port RAM with registered read for the bounded FIFO.
// Standalone; no package needed.
module mcbf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic [AW-1:0]    addr,
  input  logic             we,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write on we, register read data on re, hold otherwise
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== src/mcbf_queue.sv =====
// Short command queue between front and back of the bounded FIFO.
// Standalone register FIFO; no package needed.
module mcbf_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             not_empty
);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [CW-1:0]    count;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = entries[rptr];

  // Store pushed entries
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== src/mcbf_front.sv =====
// Front of the bounded FIFO: accepts transactions, keeps the channel table
// (open, limit, head, fill) and issues memory commands. Uses mcbf_pkg.
`include "multi_channel_bounded_fifo_macros.svh"
module mcbf_front #(
  parameter int NUM_CHANNELS = mcbf_pkg::NUM_CHANNELS_DEF,
  parameter int DEPTH        = mcbf_pkg::DEPTH_DEF,
  localparam int ADDR_W      = mcbf_pkg::addr_w(NUM_CHANNELS, DEPTH)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_ready,
  input  logic [1:0]                     kind,
  input  logic [mcbf_pkg::CHANNEL_W-1:0] channel,
  input  logic [mcbf_pkg::DATA_W-1:0]    write_data,
  input  logic [mcbf_pkg::CAP_W-1:0]     capacity_limit,
  input  logic                           q_full,
  output logic                           push,
  output mcbf_pkg::cmd_ctl_t             push_ctl,
  output logic [ADDR_W-1:0]              push_addr,
  output logic [mcbf_pkg::DATA_W-1:0]    push_wdata
);
  import mcbf_pkg::*;

  localparam int ACT_CH = chan_count(NUM_CHANNELS);
  localparam int ACT_W  = chan_w(NUM_CHANNELS);
  localparam int SLOT_W = slot_w(DEPTH);
  localparam int CNT_W  = cnt_w(DEPTH);
  localparam int SUM_W  = SLOT_W + 1;

  logic              chan_open [ACT_CH];
  logic [CNT_W-1:0]  limit     [ACT_CH];
  logic [SLOT_W-1:0] head      [ACT_CH];
  logic [CNT_W-1:0]  fill      [ACT_CH];

  kind_t             op;
  logic              acc;
  logic [ACT_W-1:0]  ch_idx;
  logic              ch_ok;
  logic [CNT_W-1:0]  fill_sel;
  logic [CNT_W-1:0]  limit_sel;
  logic [SLOT_W-1:0] head_sel;
  logic [SUM_W-1:0]  tail_sum;
  logic [SLOT_W-1:0] tail_slot;
  logic [SLOT_W-1:0] head_inc;
  logic [ACT_W-1:0]  free_idx;
  logic              found;
  logic [CNT_W-1:0]  limit_new;
  logic              do_open;
  logic              do_close;
  logic              do_send;
  logic              do_recv;
  status_t           st;

  assign op        = kind_t'(kind);
  assign req_ready = !q_full;
  assign acc       = req_valid && req_ready;
  assign ch_idx    = ACT_W'(channel);
  assign ch_ok     = (32'(channel) < 32'(NUM_CHANNELS)) && chan_open[ch_idx];
  assign fill_sel  = fill[ch_idx];
  assign limit_sel = limit[ch_idx];
  assign head_sel  = head[ch_idx];

  // Ring arithmetic within the channel's region
  assign tail_sum  = SUM_W'(head_sel) + SUM_W'(fill_sel);
  assign tail_slot = (tail_sum >= SUM_W'(DEPTH)) ? SLOT_W'(tail_sum - SUM_W'(DEPTH))
                                                 : SLOT_W'(tail_sum);
  assign head_inc  = (head_sel == SLOT_W'(DEPTH - 1)) ? '0 : head_sel + 1'b1;
  assign limit_new = (32'(capacity_limit) > 32'(DEPTH)) ? CNT_W'(DEPTH)
                                                        : CNT_W'(capacity_limit);

  // Find the lowest free channel
  always_comb begin
    found    = 1'b0;
    free_idx = '0;
    for (int i = ACT_CH - 1; i >= 0; i--) begin
      if (!chan_open[i]) begin
        found    = 1'b1;
        free_idx = ACT_W'(i);
      end
    end
  end

  // Classify the transaction
  always_comb begin
    do_open  = 1'b0;
    do_close = 1'b0;
    do_send  = 1'b0;
    do_recv  = 1'b0;
    st       = ST_OK;
    priority if (op == KIND_OPEN) begin
      if (found) begin
        do_open = 1'b1;
      end else begin
        st = ST_NO_FREE;
      end
    end else if (!ch_ok) begin
      st = ST_NO_CHANNEL;
    end else if (op == KIND_CLOSE) begin
      do_close = 1'b1;
    end else if (op == KIND_SEND) begin
      if (fill_sel >= limit_sel) begin
        st = ST_WOULD_BLOCK;
      end else begin
        do_send = 1'b1;
      end
    end else begin
      if (fill_sel == '0) begin
        st = ST_WOULD_BLOCK;
      end else begin
        do_recv = 1'b1;
      end
    end
  end

  // Build the memory command
  always_comb begin
    push                  = acc;
    push_ctl.status       = st;
    push_ctl.opened_index = do_open ? CHANNEL_W'(free_idx) : '0;
    push_ctl.rd           = do_recv;
    push_ctl.wr           = do_send;
    push_addr             = {ch_idx, (do_send ? tail_slot : head_sel)};
    push_wdata            = write_data;
  end

  // Update the channel table on accepted transactions
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ACT_CH; i++) begin
        chan_open[i] <= 1'b0;
        limit[i]     <= '0;
        head[i]      <= '0;
        fill[i]      <= '0;
      end
    end else if (acc) begin
      if (do_open) begin
        chan_open[free_idx] <= 1'b1;
        limit[free_idx]     <= limit_new;
        head[free_idx]      <= '0;
        fill[free_idx]      <= '0;
      end
      if (do_close) begin
        chan_open[ch_idx] <= 1'b0;
        head[ch_idx]      <= '0;
        fill[ch_idx]      <= '0;
      end
      if (do_send) begin
        fill[ch_idx] <= fill_sel + 1'b1;
      end
      if (do_recv) begin
        head[ch_idx] <= head_inc;
        fill[ch_idx] <= fill_sel - 1'b1;
      end
    end
  end

  `MCBF_ASSERT_IMPL(a_fill_within_limit, ch_ok, fill_sel <= limit_sel)
  `MCBF_ASSERT_NEXT(a_open_marks_channel, acc && do_open, chan_open[$past(free_idx)])
  `MCBF_ASSERT_IMPL(a_push_has_room, push, !q_full)

endmodule

// ===== src/mcbf_back.sv =====
// Back of the bounded FIFO: executes queued memory commands on the message
// RAM and registers results. Uses mcbf_pkg and mcbf_ram.
`include "multi_channel_bounded_fifo_macros.svh"
module mcbf_back #(
  parameter int NUM_CHANNELS = mcbf_pkg::NUM_CHANNELS_DEF,
  parameter int DEPTH        = mcbf_pkg::DEPTH_DEF,
  localparam int ADDR_W      = mcbf_pkg::addr_w(NUM_CHANNELS, DEPTH)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_valid,
  input  mcbf_pkg::cmd_ctl_t             q_ctl,
  input  logic [ADDR_W-1:0]              q_addr,
  input  logic [mcbf_pkg::DATA_W-1:0]    q_wdata,
  output logic                           q_pop,
  output logic                           rsp_valid,
  input  logic                           rsp_ready,
  output logic [1:0]                     status,
  output logic [mcbf_pkg::CHANNEL_W-1:0] opened_index,
  output logic [mcbf_pkg::DATA_W-1:0]    read_data
);
  import mcbf_pkg::*;

  logic              pend_valid;
  cmd_ctl_t          pend_ctl;
  logic              pend_adv;
  logic [DATA_W-1:0] ram_rdata;

  assign pend_adv = pend_valid && (!rsp_valid || rsp_ready);
  assign q_pop    = q_valid && (!pend_valid || pend_adv);

  mcbf_ram #(
    .WIDTH (DATA_W),
    .DEPTH (2 ** ADDR_W)
  ) u_ram (
    .clk   (clk),
    .addr  (q_addr),
    .we    (q_pop && q_ctl.wr),
    .wdata (q_wdata),
    .re    (q_pop && q_ctl.rd),
    .rdata (ram_rdata)
  );

  // Hold the command while its RAM read completes
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (q_pop) begin
      pend_valid <= 1'b1;
    end else if (pend_adv) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      pend_ctl <= q_ctl;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (pend_adv) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_adv) begin
      status       <= pend_ctl.status;
      opened_index <= pend_ctl.opened_index;
      read_data    <= pend_ctl.rd ? ram_rdata : '0;
    end
  end

  `MCBF_ASSERT_IMPL(a_data_only_on_ok, rsp_valid && (status != ST_OK), read_data == '0)
  `MCBF_ASSERT_NEXT(a_rdata_held_in_stall, pend_valid && pend_ctl.rd && !pend_adv, $stable(ram_rdata))
  `MCBF_ASSERT_IMPL(a_single_mem_op, q_valid, !(q_ctl.rd && q_ctl.wr))

endmodule

// ===== src/multi_channel_bounded_fifo.sv =====
// A result passes from the front, which classifies it into the command queue, to the back,
// which does the RAM access, and then to the output register.
// Throughput: one transaction per cycle while rsp_ready stays high; set by the one RAM port.
// Reset clears the channel table, the command queue and the pending and result valid flags;
// the message RAM is not cleared, so there is no startup sweep.
// Depends on mcbf_pkg, mcbf_front, mcbf_queue and mcbf_back.
module multi_channel_bounded_fifo #(
  parameter int NUM_CHANNELS = mcbf_pkg::NUM_CHANNELS_DEF,
  parameter int DEPTH        = mcbf_pkg::DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_ready,
  input  logic [1:0]                     kind,
  input  logic [mcbf_pkg::CHANNEL_W-1:0] channel,
  input  logic [mcbf_pkg::DATA_W-1:0]    write_data,
  input  logic [mcbf_pkg::CAP_W-1:0]     capacity_limit,
  output logic                           rsp_valid,
  input  logic                           rsp_ready,
  output logic [1:0]                     status,
  output logic [mcbf_pkg::CHANNEL_W-1:0] opened_index,
  output logic [mcbf_pkg::DATA_W-1:0]    read_data
);
  import mcbf_pkg::*;

  localparam int ADDR_W = addr_w(NUM_CHANNELS, DEPTH);
  localparam int CTL_W  = $bits(cmd_ctl_t);
  localparam int Q_W    = CTL_W + ADDR_W + DATA_W;

  logic              q_full;
  logic              q_not_empty;
  logic              push;
  logic              pop;
  cmd_ctl_t          f_ctl;
  logic [ADDR_W-1:0] f_addr;
  logic [DATA_W-1:0] f_wdata;
  logic [Q_W-1:0]    q_in;
  logic [Q_W-1:0]    q_out;
  cmd_ctl_t          b_ctl;
  logic [ADDR_W-1:0] b_addr;
  logic [DATA_W-1:0] b_wdata;

  mcbf_front #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .DEPTH        (DEPTH)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_ready      (req_ready),
    .kind           (kind),
    .channel        (channel),
    .write_data     (write_data),
    .capacity_limit (capacity_limit),
    .q_full         (q_full),
    .push           (push),
    .push_ctl       (f_ctl),
    .push_addr      (f_addr),
    .push_wdata     (f_wdata)
  );

  // Pack and unpack queue entries
  assign q_in = {f_ctl, f_addr, f_wdata};
  assign {b_ctl, b_addr, b_wdata} = q_out;

  mcbf_queue #(
    .WIDTH (Q_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (q_in),
    .pop       (pop),
    .pop_data  (q_out),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  mcbf_back #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .DEPTH        (DEPTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_not_empty),
    .q_ctl        (b_ctl),
    .q_addr       (b_addr),
    .q_wdata      (b_wdata),
    .q_pop        (pop),
    .rsp_valid    (rsp_valid),
    .rsp_ready    (rsp_ready),
    .status       (status),
    .opened_index (opened_index),
    .read_data    (read_data)
  );

endmodule

// ===== tb/sv/multi_channel_bounded_fifo_checker.sv =====
// Checker for the multi-channel bounded FIFO: watches requests and results, predicts
// each result from its own channel table and compares in order.
// Depends on mcbf_pkg for the operation and status codes.
`timescale 1ns / 100ps

module multi_channel_bounded_fifo_checker
  import mcbf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  input  logic                 req_ready,
  input  logic [1:0]           kind,
  input  logic [CHANNEL_W-1:0] channel,
  input  logic [DATA_W-1:0]    write_data,
  input  logic [CAP_W-1:0]     capacity_limit,
  input  logic                 rsp_valid,
  input  logic                 rsp_ready,
  input  logic [1:0]           status,
  input  logic [CHANNEL_W-1:0] opened_index,
  input  logic [DATA_W-1:0]    read_data,
  output int                   mismatch_count,
  output int                   outcomes_awaited
);

  localparam int NCH   = NUM_CHANNELS_DEF;
  localparam int DEPTH = DEPTH_DEF;

  typedef struct packed {
    status_t              status;
    logic [CHANNEL_W-1:0] opened;
    logic [DATA_W-1:0]    data;
  } op_outcome_t;

  // Shadow of the channel table and the message words
  logic              chan_open  [NCH];
  logic [CAP_W-1:0]  chan_limit [NCH];
  logic [3:0]        chan_head  [NCH];
  logic [CAP_W-1:0]  chan_fill  [NCH];
  logic [DATA_W-1:0] chan_words [NCH][DEPTH];

  op_outcome_t awaited_outcomes[$];

  // Apply one operation to the shadow table and return its outcome
  function automatic op_outcome_t queue_op_outcome(kind_t k, logic [CHANNEL_W-1:0] ch,
                                                   logic [DATA_W-1:0] wd,
                                                   logic [CAP_W-1:0] cap);
    op_outcome_t r;
    logic [3:0]  slot;
    bit          found;
    r = '0;
    r.status = ST_OK;
    found = 0;
    if (k == KIND_OPEN) begin
      r.status = ST_NO_FREE;
      for (int i = 0; i < NCH; i++) begin
        if (!found && !chan_open[i]) begin
          found = 1;
          chan_open[i]  = 1'b1;
          chan_limit[i] = (cap > DEPTH) ? CAP_W'(DEPTH) : cap;
          chan_head[i]  = '0;
          chan_fill[i]  = '0;
          r.opened = CHANNEL_W'(i);
          r.status = ST_OK;
        end
      end
    end else if (ch >= NCH || !chan_open[ch]) begin
      r.status = ST_NO_CHANNEL;
    end else if (k == KIND_CLOSE) begin
      chan_open[ch] = 1'b0;
      chan_head[ch] = '0;
      chan_fill[ch] = '0;
    end else if (k == KIND_SEND) begin
      if (chan_fill[ch] >= chan_limit[ch]) begin
        r.status = ST_WOULD_BLOCK;
      end else begin
        slot = chan_head[ch] + chan_fill[ch][3:0];
        chan_words[ch][slot] = wd;
        chan_fill[ch] = chan_fill[ch] + 1'b1;
      end
    end else begin
      if (chan_fill[ch] == 0) begin
        r.status = ST_WOULD_BLOCK;
      end else begin
        r.data = chan_words[ch][chan_head[ch]];
        chan_head[ch] = chan_head[ch] + 1'b1;
        chan_fill[ch] = chan_fill[ch] - 1'b1;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at %0t: %s got 0x%0h, want 0x%0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    op_outcome_t want;
    if (rst) begin
      for (int i = 0; i < NCH; i++) begin
        chan_open[i]  = 1'b0;
        chan_limit[i] = '0;
        chan_head[i]  = '0;
        chan_fill[i]  = '0;
      end
      awaited_outcomes.delete();
      outcomes_awaited = 0;
    end else begin
      // Compare a returned transaction with the oldest expectation
      if (rsp_valid && rsp_ready) begin
        if (awaited_outcomes.size() == 0) begin
          report_mismatch("unexpected result, status", 32'(status), 32'(0));
        end else begin
          want = awaited_outcomes.pop_front();
          if (status !== want.status)
            report_mismatch("status", 32'(status), 32'(want.status));
          if (opened_index !== want.opened)
            report_mismatch("opened_index", 32'(opened_index), 32'(want.opened));
          if (read_data !== want.data)
            report_mismatch("read_data", read_data, want.data);
        end
      end
      // Predict each accepted transaction
      if (req_valid && req_ready)
        awaited_outcomes.push_back(queue_op_outcome(kind_t'(kind), channel, write_data,
                                                    capacity_limit));
      outcomes_awaited = awaited_outcomes.size();
    end
  end

endmodule

// ===== tb/sv/multi_channel_bounded_fifo_tb.sv =====
// Top of the multi-channel bounded FIFO testbench: clock, reset, operation
// stimulus and result back-pressure. Depends on mcbf_pkg and the checker.
`timescale 1ns / 100ps

module multi_channel_bounded_fifo_tb;
  import mcbf_pkg::*;

  localparam int RANDOM_OPS = 1150;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 req_valid = 1'b0;
  logic                 req_ready;
  logic [1:0]           kind = '0;
  logic [CHANNEL_W-1:0] channel = '0;
  logic [DATA_W-1:0]    write_data = '0;
  logic [CAP_W-1:0]     capacity_limit = '0;
  logic                 rsp_valid;
  logic                 rsp_ready = 1'b0;
  logic [1:0]           status;
  logic [CHANNEL_W-1:0] opened_index;
  logic [DATA_W-1:0]    read_data;
  int                   mismatch_count;
  int                   outcomes_awaited;
  bit                   steady = 1'b0;
  int                   ready_left = 0;
  int                   stall_left = 0;

  multi_channel_bounded_fifo uut (
    .clk, .rst, .req_valid, .req_ready, .kind, .channel, .write_data, .capacity_limit,
    .rsp_valid, .rsp_ready, .status, .opened_index, .read_data
  );

  multi_channel_bounded_fifo_checker checker_i (
    .clk, .rst, .req_valid, .req_ready, .kind, .channel, .write_data, .capacity_limit,
    .rsp_valid, .rsp_ready, .status, .opened_index, .read_data,
    .mismatch_count, .outcomes_awaited
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  // Mostly short gaps, a few long ones, none during a steady stretch
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // Alternate ready runs with stalls on the result side
  always @(posedge clk) begin
    if (steady) begin
      rsp_ready <= 1'b1;
    end else if (ready_left > 0) begin
      rsp_ready <= 1'b1;
      ready_left <= ready_left - 1;
    end else if (stall_left > 0) begin
      rsp_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      rsp_ready <= 1'b1;
      ready_left <= $urandom_range(0, 20);
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                : $urandom_range(0, 3);
    end
  end

  // Present one operation and hold it until accepted
  task automatic issue_op(kind_t k, logic [CHANNEL_W-1:0] ch, logic [DATA_W-1:0] wd,
                          logic [CAP_W-1:0] cap);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid      <= 1'b1;
    kind           <= k;
    channel        <= ch;
    write_data     <= wd;
    capacity_limit <= cap;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
  endtask

  initial begin
    kind_t k;
    int    r;
    bit    fill_phase;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Operations on closed channels
    issue_op(KIND_RECV, 3'd0, 32'h0, 5'd0);
    issue_op(KIND_CLOSE, 3'd7, 32'h0, 5'd31);
    issue_op(KIND_SEND, 3'd3, 32'hFFFF_FFFF, 5'd0);
    // Zero capacity blocks every send
    issue_op(KIND_OPEN, 3'd5, 32'h0, 5'd0);
    issue_op(KIND_SEND, 3'd0, 32'h1234_5678, 5'd0);
    // Capacity one: full after one word, empty after one pop
    issue_op(KIND_OPEN, 3'd0, 32'h0, 5'd1);
    issue_op(KIND_SEND, 3'd1, 32'hFFFF_FFFF, 5'd0);
    issue_op(KIND_SEND, 3'd1, 32'h0, 5'd0);
    issue_op(KIND_RECV, 3'd1, 32'h0, 5'd0);
    issue_op(KIND_RECV, 3'd1, 32'h0, 5'd0);
    // Clamped and exact capacities, then run out of channels
    issue_op(KIND_OPEN, 3'd0, 32'h0, 5'd31);
    issue_op(KIND_OPEN, 3'd0, 32'h0, 5'd16);
    issue_op(KIND_OPEN, 3'd0, 32'h0, 5'd17);
    issue_op(KIND_OPEN, 3'd0, 32'h0, 5'd5);
    issue_op(KIND_OPEN, 3'd0, 32'h0, 5'd2);
    issue_op(KIND_OPEN, 3'd7, 32'hFFFF_FFFF, 5'd3);
    issue_op(KIND_OPEN, 3'd0, 32'h0, 5'd8);
    // Close drops queued words; reopen reuses the lowest free channel
    issue_op(KIND_SEND, 3'd7, 32'hA5A5_A5A5, 5'd0);
    issue_op(KIND_SEND, 3'd7, 32'h5A5A_5A5A, 5'd0);
    issue_op(KIND_RECV, 3'd7, 32'h0, 5'd0);
    issue_op(KIND_CLOSE, 3'd7, 32'h0, 5'd0);
    issue_op(KIND_RECV, 3'd7, 32'h0, 5'd0);
    issue_op(KIND_OPEN, 3'd0, 32'h0, 5'd8);
    issue_op(KIND_RECV, 3'd7, 32'h0, 5'd0);
    issue_op(KIND_CLOSE, 3'd0, 32'h0, 5'd0);

    // Random mix; alternate send-heavy and receive-heavy stretches so
    // queues fill to their limits and drain again
    fill_phase = 1'b1;
    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (n % 80 == 0) fill_phase = ~fill_phase;
      steady = (n % 300) >= 240;
      r = $urandom_range(0, 99);
      if (r < 9) k = KIND_OPEN;
      else if (r < 15) k = KIND_CLOSE;
      else if (r < (fill_phase ? 70 : 45)) k = KIND_SEND;
      else k = KIND_RECV;
      r = $urandom_range(0, 99);
      issue_op(k, CHANNEL_W'($urandom_range(0, 7)), $urandom,
               (r < 8) ? 5'd0 : (r < 80) ? CAP_W'($urandom_range(1, 16))
                                         : CAP_W'($urandom_range(17, 31)));
    end
    req_valid <= 1'b0;
    steady = 1'b0;

    // Let the checker record the last transaction, then drain outstanding results
    @(posedge clk);
    while (outcomes_awaited != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== multi_channel_bounded_fifo.f =====
+incdir+src
src/mcbf_pkg.sv
src/mcbf_ram.sv
src/mcbf_queue.sv
src/mcbf_front.sv
src/mcbf_back.sv
src/multi_channel_bounded_fifo.sv
tb/sv/multi_channel_bounded_fifo_checker.sv
tb/sv/multi_channel_bounded_fifo_tb.sv
